// ===== sv/lrf_pkg.sv =====
`default_nettype none

package lrf_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned RES_W          = 32;
  localparam int unsigned SLOPE_SHIFT    = 17;
  localparam int unsigned ICPT_SHIFT     = 9;
  localparam int unsigned QKEEP          = 34;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DEGEN    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
    logic                     last;
  } lrf_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    status_e                 status;
  } lrf_out_t;

  typedef enum logic [2:0] {
    OP_N_SXX   = 3'd0,
    OP_SX_SX   = 3'd1,
    OP_N_SXY   = 3'd2,
    OP_SX_SY   = 3'd3,
    OP_SXX_SY  = 3'd4,
    OP_SX_SXY  = 3'd5
  } mul_op_e;

  typedef enum logic {
    DIV_SLOPE = 1'b0,
    DIV_ICPT  = 1'b1
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MLOAD = 3'd1,
    ST_MRUN  = 3'd2,
    ST_MCAP  = 3'd3,
    ST_DLOAD = 3'd4,
    ST_DRUN  = 3'd5,
    ST_DCAP  = 3'd6,
    ST_EMIT  = 3'd7
  } lrf_state_e;

  typedef struct packed {
    logic    acc;
    logic    mul_load;
    logic    mul_step;
    logic    mul_neg;
    logic    mul_cap;
    mul_op_e mul_op;
    logic    div_load;
    logic    div_step;
    logic    div_cap;
    div_op_e div_op;
    logic    emit;
  } lrf_cmd_t;

  typedef struct packed {
    logic ovf;
    logic den_pos;
    logic out_free;
  } lrf_sts_t;

  function automatic int unsigned cnt_width(int unsigned maxp);
    return $clog2(maxp + 1);
  endfunction

  function automatic int unsigned sum_width(int unsigned maxp);
    return DATA_W + $clog2(maxp) + 1;
  endfunction

  function automatic int unsigned psum_width(int unsigned maxp);
    return 2 * DATA_W + $clog2(maxp) + 1;
  endfunction

  function automatic int unsigned num_width(int unsigned maxp);
    return psum_width(maxp) + sum_width(maxp) + 1;
  endfunction

  function automatic int unsigned quo_width(int unsigned maxp);
    return num_width(maxp) + SLOPE_SHIFT;
  endfunction

endpackage

`default_nettype wire

// ===== sv/linear_regression_fit.sv =====
// Least-squares line fit over a set of Q8.8 points.
// Input channel (in_valid_i/in_ready_o/in_data_i): one (x, y) point per beat,
// last marks the final point of a set. Output channel (out_valid_o/
// out_ready_i/out_data_o): one beat per set with slope and intercept in
// Q16.16, rounded and saturated, and a status code (ok, zero denominator,
// more than MAX_POINTS points; on a failed fit slope and intercept are zero).
// Throughput: points that are not last are taken one per cycle, back to back.
// After a last point the input stalls while one shift-add multiplier runs
// six products of W = 17 + log2(MAX_POINTS) steps each and one restoring
// divider runs two quotients of Q = 68 + 2*log2(MAX_POINTS) steps each,
// until the result is loaded. A zero denominator or an overflowed set
// skips the rest after two products. The result sits in an output
// register, so the next set is taken while it waits; if the receiver still
// holds the previous result, the block holds in its final step until the
// register frees.
// Reset clears the sums, the point count and the output valid.
`default_nettype none

module linear_regression_fit import lrf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire lrf_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output lrf_out_t     out_data_o
);

  lrf_cmd_t cmd;
  lrf_sts_t sts;

  lrf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrf_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/lrf_datapath.sv =====
`default_nettype none

module lrf_datapath import lrf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire lrf_in_t  in_data_i,
  input  wire lrf_cmd_t cmd_i,
  output lrf_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output lrf_out_t      out_data_o
);

  localparam int unsigned CW  = cnt_width(MAX_POINTS);
  localparam int unsigned SXW = sum_width(MAX_POINTS);
  localparam int unsigned SPW = psum_width(MAX_POINTS);
  localparam int unsigned NW  = num_width(MAX_POINTS);
  localparam int unsigned DW  = quo_width(MAX_POINTS);

  logic [CW-1:0]           cnt_q;
  logic                    ovf_q;
  logic signed [SXW-1:0]   sx_q, sy_q;
  logic signed [SPW-1:0]   sxy_q, sxx_q;
  logic signed [2*DATA_W-1:0] pxy, pxx;
  logic                    full;

  logic signed [NW-1:0]    ma_q, acc_q, addend, acc_d;
  logic signed [SXW-1:0]   mb_q;
  logic signed [NW-1:0]    op_a;
  logic signed [SXW-1:0]   op_b, n_ext;
  logic signed [NW-1:0]    t_q, den_q, na_q, nb_q;

  logic signed [NW-1:0]    num_sel;
  logic                    num_neg, neg_q;
  logic [NW-1:0]           num_mag;
  logic [DW-1:0]           dv_q, dv_load;
  logic [NW-1:0]           rem_q, rem_sh, den_u;
  logic                    rem_ge;
  logic                    q_big, q_sat;
  logic [QKEEP-1:0]        q_mag;
  logic [RES_W-1:0]        q_res;
  logic signed [RES_W-1:0] slope_q, icpt_q;

  lrf_out_t                out_q, out_d;
  logic                    out_valid_q;

  assign pxy  = $signed(in_data_i.x_value) * $signed(in_data_i.y_value);
  assign pxx  = $signed(in_data_i.x_value) * $signed(in_data_i.x_value);
  assign full = (cnt_q == CW'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (cmd_i.acc) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        sx_q  <= sx_q + SXW'($signed(in_data_i.x_value));
        sy_q  <= sy_q + SXW'($signed(in_data_i.y_value));
        sxy_q <= sxy_q + SPW'(pxy);
        sxx_q <= sxx_q + SPW'(pxx);
      end
    end
  end

  assign n_ext = $signed({{(SXW-CW){1'b0}}, cnt_q});

  always_comb begin
    case (cmd_i.mul_op)
      OP_N_SXX: begin
        op_a = NW'(sxx_q);
        op_b = n_ext;
      end
      OP_SX_SX: begin
        op_a = NW'(sx_q);
        op_b = sx_q;
      end
      OP_N_SXY: begin
        op_a = NW'(sxy_q);
        op_b = n_ext;
      end
      OP_SX_SY: begin
        op_a = NW'(sy_q);
        op_b = sx_q;
      end
      OP_SXX_SY: begin
        op_a = NW'(sxx_q);
        op_b = sy_q;
      end
      OP_SX_SXY: begin
        op_a = NW'(sxy_q);
        op_b = sx_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign addend = mb_q[0] ? ma_q : '0;
  assign acc_d  = cmd_i.mul_neg ? (acc_q - addend) : (acc_q + addend);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      ma_q  <= op_a;
      mb_q  <= op_b;
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      ma_q  <= ma_q <<< 1;
      mb_q  <= mb_q >>> 1;
      acc_q <= acc_d;
    end
    if (cmd_i.mul_cap) begin
      case (cmd_i.mul_op)
        OP_N_SXX, OP_N_SXY, OP_SXX_SY: t_q <= acc_q;
        OP_SX_SX:  den_q <= t_q - acc_q;
        OP_SX_SY:  na_q  <= t_q - acc_q;
        OP_SX_SXY: nb_q  <= t_q - acc_q;
        default: ;
      endcase
    end
  end

  assign num_sel = (cmd_i.div_op == DIV_SLOPE) ? na_q : nb_q;
  assign num_neg = num_sel[NW-1];
  assign num_mag = num_neg ? NW'(-num_sel) : NW'(num_sel);
  assign dv_load = (cmd_i.div_op == DIV_SLOPE) ?
                   {num_mag, {SLOPE_SHIFT{1'b0}}} :
                   {{(SLOPE_SHIFT-ICPT_SHIFT){1'b0}}, num_mag, {ICPT_SHIFT{1'b0}}};

  assign den_u  = NW'(den_q);
  assign rem_sh = {rem_q[NW-2:0], dv_q[DW-1]};
  assign rem_ge = (rem_sh >= den_u);

  assign q_big = |dv_q[DW-1:QKEEP];
  assign q_mag = QKEEP'(({1'b0, dv_q[QKEEP-1:0]} + 1'b1) >> 1);
  assign q_sat = q_big || (|q_mag[QKEEP-1:RES_W-1]);

  always_comb begin
    if (q_sat) begin
      q_res = neg_q ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else if (neg_q) begin
      q_res = RES_W'(-q_mag[RES_W-1:0]);
    end else begin
      q_res = q_mag[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dv_q  <= dv_load;
      rem_q <= '0;
      neg_q <= num_neg;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - den_u) : rem_sh;
      dv_q  <= {dv_q[DW-2:0], rem_ge};
    end
    if (cmd_i.div_cap) begin
      if (cmd_i.div_op == DIV_SLOPE) begin
        slope_q <= $signed(q_res);
      end else begin
        icpt_q <= $signed(q_res);
      end
    end
  end

  assign sts_o.ovf      = ovf_q;
  assign sts_o.den_pos  = !den_q[NW-1] && (|den_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.slope     = '0;
    out_d.intercept = '0;
    if (ovf_q) begin
      out_d.status = STATUS_OVERFLOW;
    end else if (!sts_o.den_pos) begin
      out_d.status = STATUS_DEGEN;
    end else begin
      out_d.status    = STATUS_OK;
      out_d.slope     = slope_q;
      out_d.intercept = icpt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/lrf_ctrl.sv =====
`default_nettype none

module lrf_ctrl import lrf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_last_i,
  output logic          in_ready_o,
  input  wire lrf_sts_t sts_i,
  output lrf_cmd_t      cmd_o
);

  localparam int unsigned SXW = sum_width(MAX_POINTS);
  localparam int unsigned DW  = quo_width(MAX_POINTS);
  localparam int unsigned CTW = $clog2(DW);
  localparam logic [CTW-1:0] MUL_LAST = CTW'(SXW - 1);
  localparam logic [CTW-1:0] DIV_LAST = CTW'(DW - 1);

  lrf_state_e     state_q, state_d;
  mul_op_e        op_q, op_d, op_next;
  div_op_e        dsel_q, dsel_d;
  logic [CTW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_N_SXX;
      dsel_q  <= DIV_SLOPE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      dsel_q  <= dsel_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    case (op_q)
      OP_N_SXX:  op_next = OP_SX_SX;
      OP_SX_SX:  op_next = OP_N_SXY;
      OP_N_SXY:  op_next = OP_SX_SY;
      OP_SX_SY:  op_next = OP_SXX_SY;
      OP_SXX_SY: op_next = OP_SX_SXY;
      default:   op_next = OP_N_SXX;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    dsel_d       = dsel_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.mul_op = op_q;
    cmd_o.div_op = dsel_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) begin
            op_d    = OP_N_SXX;
            state_d = ST_MLOAD;
          end
        end
      end
      ST_MLOAD: begin
        if (op_q == OP_N_SXY && (sts_i.ovf || !sts_i.den_pos)) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.mul_load = 1'b1;
          cnt_d          = '0;
          state_d        = ST_MRUN;
        end
      end
      ST_MRUN: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_neg  = (cnt_q == MUL_LAST);
        if (cnt_q == MUL_LAST) begin
          state_d = ST_MCAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MCAP: begin
        cmd_o.mul_cap = 1'b1;
        if (op_q == OP_SX_SXY) begin
          dsel_d  = DIV_SLOPE;
          state_d = ST_DLOAD;
        end else begin
          op_d    = op_next;
          state_d = ST_MLOAD;
        end
      end
      ST_DLOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DRUN;
      end
      ST_DRUN: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_DCAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DCAP: begin
        cmd_o.div_cap = 1'b1;
        if (dsel_q == DIV_SLOPE) begin
          dsel_d  = DIV_ICPT;
          state_d = ST_DLOAD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lrf_checker.sv =====
`default_nettype none

module lrf_checker import lrf_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire lrf_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire lrf_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |->
      out_data_o.slope == '0 && out_data_o.intercept == '0)
    else $error("failed fit carries nonzero fields");

  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> !in_ready_o)
    else $error("input not stalled after last point");

  a_result_after_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while accepting points");

endmodule

bind linear_regression_fit lrf_checker u_lrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
